### src/nsc_pkg.sv
// shared types, constants and helpers of the non-overlapping substring counter
package nsc_pkg;

  localparam int unsigned MAX_PATTERN_DEF = 8;   // default window depth
  localparam int unsigned PAT_BYTES       = 8;   // bytes held by the pattern register
  localparam int unsigned PAT_W           = 8 * PAT_BYTES;
  localparam int unsigned LEN_W           = 4;
  localparam int unsigned CNT_W           = 32;
  localparam int unsigned BLK_W           = 3;
  localparam int unsigned ADDR_W          = 4;
  localparam int unsigned APB_DW          = 64;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // register index codes, taken from paddr[3]
  localparam logic REG_PATTERN = 1'b0;
  localparam logic REG_LENGTH  = 1'b1;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1);

  // per-item control seen by every cell
  typedef struct packed {
    logic shift;  // item accepted, window moves
    logic flush;  // whitespace, word ends
  } nsc_ctrl_t;

  // per-item control for the hit tally
  typedef struct packed {
    logic accept;
    logic clear;
    logic blank;
    logic match;
  } nsc_step_t;

  // space, tab, line feed, vertical tab, form feed, carriage return
  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'h20) || (c inside {[8'h09:8'h0D]});
  endfunction

  // pattern byte that window slot idx must equal for a pattern of length len
  function automatic logic [7:0] pat_sel(input logic [PAT_W-1:0] pat,
                                         input logic [LEN_W-1:0] len,
                                         input int unsigned idx);
    int pos;
    pos = int'(len) - 1 - int'(idx);
    if (pos < 0 || pos >= int'(PAT_BYTES)) begin
      return 8'h00;
    end
    return pat[{3'(pos), 3'b000} +: 8];
  endfunction

endpackage

### src/nsc_cell.sv
// one window slot: holds a word byte and checks its input byte against the pattern
module nsc_cell
  import nsc_pkg::*;
#(
  parameter int unsigned Idx = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  nsc_ctrl_t        ctrl_i,
  input  logic [7:0]       byte_i,
  input  logic             valid_i,
  input  logic [PAT_W-1:0] pattern_i,
  input  logic [LEN_W-1:0] len_i,
  output logic [7:0]       byte_o,
  output logic             valid_o,
  output logic             ok_o
);

  logic [7:0] byte_q;
  logic       valid_q, valid_d;
  logic       need;

  assign valid_d = valid_i && !ctrl_i.flush;

  // slot takes part only when it lies inside the pattern length
  assign need = int'(len_i) > int'(Idx);
  assign ok_o = !need || (valid_d && (byte_i == pat_sel(pattern_i, len_i, Idx)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.shift) begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      byte_q <= byte_i;
    end
  end

  assign byte_o  = byte_q;
  assign valid_o = valid_q;

endmodule

### src/nsc_tally.sv
// blocking counter after a hit and saturating hit count
module nsc_tally
  import nsc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  nsc_step_t        step_i,
  input  logic [LEN_W-1:0] len_i,
  output logic             hit_o,
  output logic [CNT_W-1:0] count_o
);

  logic [BLK_W-1:0] blocked_q, blocked_d, blk_base;
  logic [CNT_W-1:0] count_q, count_d, cnt_base;
  logic             hit;

  assign blk_base = step_i.clear ? '0 : blocked_q;
  assign cnt_base = step_i.clear ? '0 : count_q;

  always_comb begin
    hit       = 1'b0;
    blocked_d = blk_base;
    if (step_i.blank) begin
      blocked_d = '0;
    end else if (blk_base != '0) begin
      blocked_d = blk_base - BLK_W'(1);
    end else if (step_i.match) begin
      hit       = 1'b1;
      blocked_d = BLK_W'(len_i - LEN_W'(1));
    end
  end

  assign count_d = (hit && cnt_base != CNT_MAX) ? cnt_base + CNT_W'(1) : cnt_base;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blocked_q <= '0;
      count_q   <= '0;
    end else if (step_i.accept) begin
      blocked_q <= blocked_d;
      count_q   <= count_d;
    end
  end

  assign hit_o   = hit;
  assign count_o = count_d;

endmodule

### src/nonoverlap_substring_counter.sv
// top level of the non-overlapping substring counter
//
// counts non-overlapping occurrences of a 1 to 8 byte pattern in a byte stream
// - input channel s_axis: tdata is the text byte, tuser is clear_count, which
//   zeroes the count, the word window and the blocking before that byte
// - output channel m_axis: one item per input item; tuser is the hit flag,
//   tdata the running count after this byte, saturating at all ones
// - apb port: pattern bytes at address 0 (64 bits, byte 0 lowest), pattern
//   length at address 8 (4 bits); write only while the stream is idle
// - output valid follows in the cycle after input accept; throughput is one item
//   per cycle unless the receiver stalls, via the combinational cell row compare
// - the window is a row of MaxPattern cells, each holding one byte and a valid
//   bit and passing them to its neighbor on every accepted item
// - whitespace ends the word: all cells go invalid and no hit is flagged
// - the output register holds an item until taken; while it is full and the
//   receiver stalls, s_axis_tready drops, otherwise a new item enters each cycle
// - reset empties the window and the output register, clears the count, and
//   loads pattern 0 with length 1
module nonoverlap_substring_counter
  import nsc_pkg::*;
#(
  parameter int unsigned MaxPattern = MAX_PATTERN_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // input stream
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,   // [7:0] text_byte
  input  logic              s_axis_tuser,   // [0] clear_count
  // output stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [CNT_W-1:0]  m_axis_tdata,   // [31:0] total_hits
  output logic              m_axis_tuser,   // [0] hit
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  // configuration registers
  logic [PAT_W-1:0] pattern_q;
  logic [LEN_W-1:0] len_q;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= '0;
      len_q     <= LEN_RESET;
    end else if (cfg_wr) begin
      case (paddr[3])
        REG_PATTERN: pattern_q <= pwdata[PAT_W-1:0];
        REG_LENGTH:  len_q     <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3])
      REG_PATTERN: prdata = APB_DW'(pattern_q);
      REG_LENGTH:  prdata = APB_DW'(len_q);
      default:     prdata = '0;
    endcase
  end

  // handshake: output register frees as soon as the receiver takes it
  logic out_valid_q;
  logic accept;
  logic blank;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign blank         = is_blank(s_axis_tdata);

  nsc_ctrl_t ctrl;
  assign ctrl.shift = accept;
  assign ctrl.flush = blank;

  // row of window cells, newest byte in cell 0
  logic [7:0]            cell_byte [MaxPattern];
  logic [MaxPattern-1:0] cell_valid;
  logic [MaxPattern-1:0] cell_ok;

  for (genvar k = 0; k < MaxPattern; k++) begin : g_cell
    logic [7:0] in_byte;
    logic       in_valid;
    if (k == 0) begin : g_head
      assign in_byte  = s_axis_tdata;
      assign in_valid = 1'b1;
    end else begin : g_link
      // clear_count drops the old word before this byte enters
      assign in_byte  = cell_byte[k-1];
      assign in_valid = cell_valid[k-1] && !s_axis_tuser;
    end

    nsc_cell #(
      .Idx (k)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .byte_i    (in_byte),
      .valid_i   (in_valid),
      .pattern_i (pattern_q),
      .len_i     (len_q),
      .byte_o    (cell_byte[k]),
      .valid_o   (cell_valid[k]),
      .ok_o      (cell_ok[k])
    );
  end

  // a length of zero, or beyond the window or the pattern register, never matches
  logic len_ok;
  assign len_ok = (len_q != '0) && (int'(len_q) <= int'(MaxPattern))
               && (int'(len_q) <= int'(PAT_BYTES));

  nsc_step_t step;
  assign step.accept = accept;
  assign step.clear  = s_axis_tuser;
  assign step.blank  = blank;
  assign step.match  = len_ok && (&cell_ok);

  logic             hit;
  logic [CNT_W-1:0] count;

  nsc_tally u_tally (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .len_i   (len_q),
    .hit_o   (hit),
    .count_o (count)
  );

  // output register
  logic             hit_q;
  logic [CNT_W-1:0] count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      hit_q   <= hit;
      count_q <= count;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = hit_q;
  assign m_axis_tdata  = count_q;

endmodule

### src/nsc_checker.sv
// port-level checks of the substring counter, bound to the top level
module nsc_checker
  import nsc_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic [7:0]       s_axis_tdata,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [CNT_W-1:0] m_axis_tdata,
  input logic             m_axis_tuser
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // every accepted item yields a result on the next cycle
  a_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("result missing after accepted item");

  // an empty output register never blocks the input
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // a hit implies a nonzero count
  a_hit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata != '0)
    else $error("hit flagged with zero count");

  // an accepted space or line feed never yields a hit
  a_blank_nohit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tdata == 8'h20 || s_axis_tdata == 8'h0A)
    |=> !m_axis_tuser)
    else $error("hit flagged on whitespace");

endmodule

bind nonoverlap_substring_counter nsc_checker u_nsc_checker (.*);
